@@ hw/rtl/b64d_pkg.sv @@
package b64d_pkg;

	// Result kinds carried on the output
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [5:0] SEXTET_PLUS = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] SEXTET_DIGIT0 = 6'd52;
	localparam logic [5:0] SEXTET_LOWER_A = 6'd26;

	// Input transaction
	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_text;
	} sym_item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] data_byte;
		kind_t      kind;
		logic       run_end;
	} res_item_t;

	// Work handed from the front end to the back end: up to three bytes,
	// then an optional status result.
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  n_data;
		logic        has_status;
		kind_t       status;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	// Standard alphabet lookup
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok = 1'b1;
		r.value = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.value = 6'(c - 8'h61) + SEXTET_LOWER_A;
		end else if (c inside {[8'h30:8'h39]}) begin
			r.value = 6'(c - 8'h30) + SEXTET_DIGIT0;
		end else if (c == 8'h2B) begin
			r.value = SEXTET_PLUS;
		end else if (c == 8'h2F) begin
			r.value = SEXTET_SLASH;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/base64_stream_decoder.sv @@
// Streaming base64 decoder, standard alphabet. One character is taken per
// transaction on the sym channel, with end_of_text on the last character of a
// string; decoded bytes and a closing status (ok or malformed) leave on the res
// channel, run_end marking the last result of each character. The front end
// accepts a character every cycle while its job queue (QUEUE_DEPTH entries)
// has room; characters that finish nothing queue nothing.
// The back end drains one result per cycle, while res_stall is low, from an
// output register; a character that closes a group yields one to four results
// (three bytes plus status at most), one result per cycle without stalls.
// After a malformed character that is not the last, the rest of the string is
// dropped silently up to and including its end_of_text character.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sym_valid,
	output logic                sym_stall,
	input  b64d_pkg::sym_item_t sym_item,
	output logic                res_valid,
	input  logic                res_stall,
	output b64d_pkg::res_item_t res_item
);
	import b64d_pkg::*;

	logic full;
	logic push;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	// Character classification and group state
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.full      (full),
		.push      (push),
		.push_job  (push_job)
	);

	// Job queue between the two halves
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid)
	);

	// Result serializer
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

`ifndef NO_ASSERTIONS
	// A status result always closes the run of its character
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.kind != KIND_DATA) |-> res_item.run_end)
		else $error("status result without run_end");

	// The front end never writes into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

	// Results of one character go out without gaps
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !res_item.run_end) |=> res_valid)
		else $error("gap inside a result run");
`endif

endmodule

@@ hw/rtl/b64d_front.sv @@
module b64d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  b64d_pkg::sym_item_t sym_item,
	input  logic               full,
	output logic               push,
	output b64d_pkg::job_t     push_job
);
	import b64d_pkg::*;

	logic [17:0] held_q, held_d;
	logic [1:0]  pos_q, pos_d;
	logic        third_pad_q, third_pad_d;
	logic        err_q, err_d;
	logic        accept;
	logic        pad;
	logic        last;
	logic        bad;
	logic        has_job;
	sextet_t     sx;
	job_t        job;

	assign sym_stall = full;
	assign accept = sym_valid && !full;
	assign pad = (sym_item.symbol == PAD_CHAR);
	assign last = sym_item.end_of_text;
	assign sx = sextet_of(sym_item.symbol);

	// Classify the character against the group position
	always_comb begin
		held_d = held_q;
		pos_d = pos_q;
		third_pad_d = third_pad_q;
		err_d = err_q;
		bad = 1'b0;
		has_job = 1'b0;
		job.triple = {held_q, sx.value};
		job.n_data = 2'd0;
		job.has_status = 1'b0;
		job.status = KIND_OK;
		if (err_q) begin
			// dropping until the end of the string
			if (last) begin
				err_d = 1'b0;
				held_d = '0;
				pos_d = '0;
				third_pad_d = 1'b0;
			end
		end else begin
			case (pos_q)
				2'd0, 2'd1: begin
					if (pad || !sx.ok || last) begin
						bad = 1'b1;
					end else begin
						held_d = {held_q[11:0], sx.value};
						pos_d = pos_q + 2'd1;
					end
				end
				2'd2: begin
					if ((!pad && !sx.ok) || last) begin
						bad = 1'b1;
					end else begin
						third_pad_d = pad;
						held_d = {held_q[11:0], pad ? 6'd0 : sx.value};
						pos_d = 2'd3;
					end
				end
				default: begin
					if (pad) begin
						if (!last) begin
							bad = 1'b1;
						end else begin
							has_job = 1'b1;
							job.triple = {held_q, 6'd0};
							job.n_data = third_pad_q ? 2'd1 : 2'd2;
							job.has_status = 1'b1;
						end
					end else if (!sx.ok || third_pad_q) begin
						bad = 1'b1;
					end else begin
						has_job = 1'b1;
						job.n_data = 2'd3;
						job.has_status = last;
					end
					if (!bad) begin
						held_d = '0;
						pos_d = '0;
						third_pad_d = 1'b0;
					end
				end
			endcase
			if (bad) begin
				has_job = 1'b1;
				job.n_data = 2'd0;
				job.has_status = 1'b1;
				job.status = KIND_BAD;
				held_d = '0;
				pos_d = '0;
				third_pad_d = 1'b0;
				err_d = !last;
			end
		end
	end

	assign push = accept && has_job;
	assign push_job = job;

	// Group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q <= '0;
			third_pad_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			pos_q <= pos_d;
			third_pad_q <= third_pad_d;
			err_q <= err_d;
		end
	end

endmodule

@@ hw/rtl/b64d_queue.sv @@
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output b64d_pkg::job_t head_job,
	output logic           head_valid
);
	import b64d_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = slots_q[rd_ptr_q];

	// Pointer advance with wrap at any depth
	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/b64d_back.sv @@
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::job_t      head_job,
	input  logic                head_valid,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output b64d_pkg::res_item_t res_item
);
	import b64d_pkg::*;

	logic [1:0] step_q;
	logic       res_valid_q;
	res_item_t  res_item_q;
	logic [2:0] total;
	logic       last_step;
	logic       load;
	res_item_t  next_item;

	// Which result of the current job goes out next
	assign total = {1'b0, head_job.n_data} + {2'b00, head_job.has_status};
	assign last_step = ({1'b0, step_q} == total - 3'd1);
	assign load = head_valid && (!res_valid_q || !res_stall);
	assign pop = load && last_step;

	always_comb begin
		next_item.run_end = last_step;
		if (step_q < head_job.n_data) begin
			next_item.kind = KIND_DATA;
			case (step_q)
				2'd0: next_item.data_byte = head_job.triple[23:16];
				2'd1: next_item.data_byte = head_job.triple[15:8];
				default: next_item.data_byte = head_job.triple[7:0];
			endcase
		end else begin
			next_item.kind = head_job.status;
			next_item.data_byte = 8'd0;
		end
	end

	// Step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= '0;
			end else if (load) begin
				step_q <= step_q + 2'd1;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			res_item_q <= next_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_item_q;

endmodule

@@ tb/sv/tb_base64_stream_decoder.sv @@
`timescale 1ns / 100ps

module tb_base64_stream_decoder;
	import b64d_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 16;

	logic      clk;
	logic      arst_n;
	logic      sym_valid;
	logic      sym_stall;
	sym_item_t sym_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;

	// Idle rates in percent, and the long receiver hold-off request
	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_request = 1'b0;

	// Decoder state mirrored by the predictor
	logic [17:0] held_sextets = '0;
	logic [1:0]  group_pos = '0;
	logic        third_pad = 1'b0;
	logic        dropping = 1'b0;

	res_item_t expected_results[$];
	int        live_items = 0;
	int        mismatches = 0;
	int        cycle_count = 0;

	base64_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym_item (sym_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Alphabet lookup: {in_alphabet, six-bit value}
	function automatic logic [6:0] lookup_sextet(input logic [7:0] ch);
		logic [6:0] r;
		r = 7'd0;
		if (ch >= "A" && ch <= "Z") begin
			r = {1'b1, 6'(ch - "A")};
		end else if (ch >= "a" && ch <= "z") begin
			r = {1'b1, 6'(ch - "a" + 8'd26)};
		end else if (ch >= "0" && ch <= "9") begin
			r = {1'b1, 6'(ch - "0" + 8'd52)};
		end else if (ch == "+") begin
			r = {1'b1, SEXTET_PLUS};
		end else if (ch == "/") begin
			r = {1'b1, SEXTET_SLASH};
		end
		return r;
	endfunction

	// Character for a six-bit value
	function automatic logic [7:0] alphabet_char(input int idx);
		if (idx < 26)
			return 8'(idx) + "A";
		else if (idx < 52)
			return 8'(idx - 26) + "a";
		else if (idx < 62)
			return 8'(idx - 52) + "0";
		else if (idx == 62)
			return "+";
		return "/";
	endfunction

	function automatic void add_result(input logic [7:0] value, input kind_t k);
		res_item_t r;
		r.data_byte = value;
		r.kind = k;
		r.run_end = 1'b0;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void clear_group();
		held_sextets = '0;
		group_pos = '0;
		third_pad = 1'b0;
	endfunction

	// Expected results of one accepted character
	function automatic void decode_symbol(input sym_item_t it);
		logic [6:0]  lk;
		logic        is_pad;
		logic        bad;
		logic [23:0] triple;
		int          first;
		lk = lookup_sextet(it.symbol);
		is_pad = (it.symbol == PAD_CHAR);
		bad = 1'b0;
		first = expected_results.size();

		// Rest of a rejected string is swallowed
		if (dropping) begin
			if (it.end_of_text) begin
				dropping = 1'b0;
				clear_group();
			end
			return;
		end
		live_items++;

		case (group_pos)
			2'd0, 2'd1: begin
				if (is_pad || !lk[6] || it.end_of_text) begin
					bad = 1'b1;
				end else begin
					held_sextets = {held_sextets[11:0], lk[5:0]};
					group_pos = group_pos + 2'd1;
				end
			end
			2'd2: begin
				if ((!is_pad && !lk[6]) || it.end_of_text) begin
					bad = 1'b1;
				end else begin
					third_pad = is_pad;
					held_sextets = {held_sextets[11:0], is_pad ? 6'd0 : lk[5:0]};
					group_pos = 2'd3;
				end
			end
			default: begin
				if (is_pad) begin
					if (!it.end_of_text) begin
						bad = 1'b1;
					end else begin
						triple = {held_sextets, 6'd0};
						add_result(triple[23:16], KIND_DATA);
						if (!third_pad)
							add_result(triple[15:8], KIND_DATA);
						clear_group();
						add_result(8'd0, KIND_OK);
					end
				end else if (!lk[6] || third_pad) begin
					bad = 1'b1;
				end else begin
					triple = {held_sextets, lk[5:0]};
					add_result(triple[23:16], KIND_DATA);
					add_result(triple[15:8], KIND_DATA);
					add_result(triple[7:0], KIND_DATA);
					clear_group();
					if (it.end_of_text)
						add_result(8'd0, KIND_OK);
				end
			end
		endcase

		if (bad) begin
			add_result(8'd0, KIND_BAD);
			clear_group();
			dropping = !it.end_of_text;
		end
		if (expected_results.size() > first)
			expected_results[expected_results.size() - 1].run_end = 1'b1;
	endfunction

	function automatic void check_result(input res_item_t got);
		res_item_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result: byte %02h kind %0d run_end %b",
				$time, got.data_byte, got.kind, got.run_end);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got.data_byte !== want.data_byte || got.kind !== want.kind ||
				got.run_end !== want.run_end) begin
			$display("%0t: result mismatch: expected byte %02h kind %0d run_end %b, got byte %02h kind %0d run_end %b",
				$time, want.data_byte, want.kind, want.run_end,
				got.data_byte, got.kind, got.run_end);
			mismatches++;
		end
	endfunction

	// Both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (sym_valid && !sym_stall)
				decode_symbol(sym_item);
			if (res_valid && !res_stall)
				check_result(res_item);
		end
	end

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_request = 1'b0;
			end
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// One character transaction; called and returns at a falling edge
	task automatic send_symbol(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			sym_valid <= 1'b0;
			@(negedge clk);
		end
		sym_valid <= 1'b1;
		sym_item.symbol <= ch;
		sym_item.end_of_text <= last;
		@(posedge clk);
		while (sym_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_symbol(s[i], i == s.len() - 1);
	endtask

	// Stop offering and let all outstanding results come out
	task automatic wait_drained();
		sym_valid <= 1'b0;
		while (expected_results.size() != 0 || hold_request)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Full groups over the alphabet edges, two pads, one pad
	task automatic test_valid_strings();
		send_text("AZaz09+/");
		send_text("//==");
		send_text("+/9=");
	endtask

	// Out-of-alphabet bytes; the rest of the string is dropped
	task automatic test_bad_characters();
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'h00, 1'b1);
	endtask

	// Pad in first position, then a data character after a third-position pad
	task automatic test_misplaced_pads();
		send_symbol(PAD_CHAR, 1'b0);
		send_symbol("A", 1'b1);
		send_text("AA=A");
	endtask

	task automatic test_bad_length();
		send_text("AB");
	endtask

	// Mostly well-formed strings with random content, some of them corrupted
	task automatic test_random_strings(input int count, input int tx_idle, input int rx_idle);
		logic [7:0] text[$];
		int         target;
		int         groups;
		int         tail;
		int         pos;
		wait_drained();
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		target = live_items + count;
		while (live_items < target) begin
			text = {};
			groups = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
			repeat (groups * 4)
				text.insert(text.size(), alphabet_char($urandom_range(63)));
			tail = $urandom_range(2);
			if (tail >= 1)
				text[text.size() - 1] = PAD_CHAR;
			if (tail == 2)
				text[text.size() - 2] = PAD_CHAR;
			if ($urandom_range(99) < 30) begin
				pos = $urandom_range(text.size() - 1);
				case ($urandom_range(3))
					0: text[pos] = 8'($urandom_range(255));
					1: text[pos] = PAD_CHAR;
					2: repeat ($urandom_range(3, 1)) void'(text.pop_back());
					default: text.insert(pos, alphabet_char($urandom_range(63)));
				endcase
			end
			foreach (text[i])
				send_symbol(text[i], i == text.size() - 1);
		end
	endtask

	// Receiver holds off while full groups keep coming, so the job queue fills
	task automatic test_output_backpressure();
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		repeat (4) begin
			for (int g = 0; g < 12; g++)
				send_symbol(alphabet_char($urandom_range(63)), g == 11);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sym_valid = 1'b0;
		sym_item = '0;
		send_idle_pct = 11;
		recv_idle_pct = 55;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_valid_strings();
		test_bad_characters();
		test_misplaced_pads();
		test_bad_length();
		test_random_strings(100, 11, 55);
		test_output_backpressure();
		test_random_strings(100, 55, 11);
		test_random_strings(100, 0, 0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
